[rtl/lru_tlb_lookup_insert_macros.svh]
// Assertion helpers for the TLB RTL.
`ifndef LRU_TLB_LOOKUP_INSERT_MACROS_SVH
`define LRU_TLB_LOOKUP_INSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define LTLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define LTLB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/lrutlb_pkg.sv]
package lrutlb_pkg;

  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int PAGE_W  = 20;
  localparam int TOTAL_W = 32;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [PAGE_W-1:0] page_number;
    logic [PAGE_W-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [PAGE_W-1:0]  found_frame;
    logic [TOTAL_W-1:0] requests_seen;
    logic [TOTAL_W-1:0] hits_seen;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

[rtl/lrutlb_cell.sv]
module lrutlb_cell (
  input  logic                         clk,
  input  lrutlb_pkg::cell_ctl_t        ctl,
  input  lrutlb_pkg::entry_t           load_data,
  input  lrutlb_pkg::entry_t           right,
  input  logic [lrutlb_pkg::PAGE_W-1:0] key,
  output lrutlb_pkg::entry_t           q,
  output logic                         match
);

  lrutlb_pkg::entry_t q_next;

  always_comb begin
    priority if (ctl.load) begin
      q_next = load_data;
    end else if (ctl.shift) begin
      q_next = right;
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign match = (q.page == key);

endmodule

[rtl/lru_tlb_lookup_insert.sv]
// Channel  Direction  Valid      Stall      Payload
// req      in         req_valid  req_stall  req (mode, page_number, frame_number)
// rsp      out        rsp_valid  rsp_stall  rsp (hit, found_frame, requests_seen, hits_seen)
//
// One request beat is taken per cycle unless stalled; its response follows next cycle.
// Compare is combinational; recency shift and counter updates register together.
// Reset clears the fill count, both totals and the response valid; the slots keep
// whatever they hold and are read only below the fill count.
// A stalled response holds and stalls requests only while it waits.
`include "lru_tlb_lookup_insert_macros.svh"

module lru_tlb_lookup_insert (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  lrutlb_pkg::req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output lrutlb_pkg::rsp_t rsp
);

  localparam int N     = lrutlb_pkg::ENTRIES;
  localparam int CNT_W = lrutlb_pkg::CNT_W;
  localparam logic [N-1:0] ONES = {N{1'b1}};

  logic [CNT_W-1:0]                 fill_count, fill_count_next;
  logic [lrutlb_pkg::TOTAL_W-1:0]   request_total, request_total_next;
  logic [lrutlb_pkg::TOTAL_W-1:0]   hit_total, hit_total_next;
  logic                             req_fire;
  logic                             is_lookup;
  logic                             full;
  logic                             any_hit;
  logic [lrutlb_pkg::PAGE_W-1:0]    found;
  logic [N-1:0]                     match_raw, match_vec, prior, first;
  lrutlb_pkg::entry_t               cell_q     [N];
  lrutlb_pkg::entry_t               cell_right [N];
  lrutlb_pkg::cell_ctl_t            cell_ctl   [N];
  lrutlb_pkg::entry_t               load_data;
  lrutlb_pkg::rsp_t                 rsp_next;

  assign req_stall = rsp_valid & rsp_stall;
  assign req_fire  = req_valid & ~req_stall;
  assign is_lookup = (req.mode == lrutlb_pkg::MODE_LOOKUP);
  assign full      = (fill_count == CNT_W'(N));

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_cell
      if (j == N - 1) begin : g_end
        assign cell_right[j] = cell_q[j];
      end else begin : g_mid
        assign cell_right[j] = cell_q[j+1];
      end

      assign match_vec[j] = match_raw[j] & (CNT_W'(j) < fill_count);
      assign prior[j]     = |(match_vec & (ONES >> (N - j)));
      assign first[j]     = match_vec[j] & ~prior[j];

      always_comb begin
        cell_ctl[j] = '0;
        if (req_fire) begin
          if (is_lookup) begin
            if (any_hit) begin
              cell_ctl[j].shift = (prior[j] | match_vec[j]) & (CNT_W'(j + 1) < fill_count);
              cell_ctl[j].load  = (CNT_W'(j + 1) == fill_count);
            end
          end else if (full) begin
            cell_ctl[j].shift = (j < N - 1);
            cell_ctl[j].load  = (j == N - 1);
          end else begin
            cell_ctl[j].load  = (CNT_W'(j) == fill_count);
          end
        end
      end

      lrutlb_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[j]),
        .load_data (load_data),
        .right     (cell_right[j]),
        .key       (req.page_number),
        .q         (cell_q[j]),
        .match     (match_raw[j])
      );
    end
  endgenerate

  assign any_hit = |match_vec;

  // first is one-hot or empty, so an OR of the masked frames selects it
  always_comb begin
    found = '0;
    for (int k = 0; k < N; k++) begin
      found = found | (cell_q[k].frame & {lrutlb_pkg::PAGE_W{first[k]}});
    end
  end

  always_comb begin
    load_data.page  = req.page_number;
    load_data.frame = is_lookup ? found : req.frame_number;
  end

  always_comb begin
    fill_count_next    = fill_count;
    request_total_next = request_total;
    hit_total_next     = hit_total;
    if (is_lookup) begin
      request_total_next = request_total + 32'd1;
      if (any_hit) begin
        hit_total_next = hit_total + 32'd1;
      end
    end else if (!full) begin
      fill_count_next = fill_count + CNT_W'(1);
    end
    rsp_next.hit           = is_lookup & any_hit;
    rsp_next.found_frame   = (is_lookup & any_hit) ? found : '0;
    rsp_next.requests_seen = request_total_next;
    rsp_next.hits_seen     = hit_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      request_total <= '0;
      hit_total     <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (req_fire) begin
        fill_count    <= fill_count_next;
        request_total <= request_total_next;
        hit_total     <= hit_total_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp <= rsp_next;
    end
  end

  `LTLB_ASSERT(a_fill_grows, req_fire && req.mode == lrutlb_pkg::MODE_INSERT && fill_count != CNT_W'(N) |=> fill_count == $past(fill_count) + CNT_W'(1), "insert into a free slot did not grow the fill count")
  `LTLB_ASSERT(a_lookup_counts, req_fire && req.mode == lrutlb_pkg::MODE_LOOKUP |=> rsp_valid && rsp.requests_seen == $past(request_total) + 32'd1, "lookup beat did not advance the request total")
  `LTLB_ASSERT(a_insert_no_hit, req_fire && req.mode == lrutlb_pkg::MODE_INSERT |=> !rsp.hit && rsp.found_frame == '0 && rsp.hits_seen == $past(hit_total), "insert beat reported a hit")
  `LTLB_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp_valid && fill_count == '0, "reset left a response or entries behind")

endmodule

[tb/sv/tb_lru_tlb_lookup_insert.sv]
`timescale 1ns / 1ps

module tb_lru_tlb_lookup_insert;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int POOL_SIZE = 24;
  localparam int DRAIN_CYCLES = 8;
  localparam int PAGE_W = lrutlb_pkg::PAGE_W;
  localparam int ENTRIES = lrutlb_pkg::ENTRIES;
  localparam int TOTAL_W = lrutlb_pkg::TOTAL_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  lrutlb_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  lrutlb_pkg::rsp_t rsp;

  lru_tlb_lookup_insert DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // Shadow copy of the translation table, oldest slot first.
  logic [PAGE_W-1:0]  tlb_pages [ENTRIES];
  logic [PAGE_W-1:0]  tlb_frames[ENTRIES];
  int                 tlb_fill = 0;
  logic [TOTAL_W-1:0] lookup_total = '0;
  logic [TOTAL_W-1:0] hit_total = '0;

  lrutlb_pkg::req_t pending_reqs[$];
  lrutlb_pkg::rsp_t expected_rsps[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  logic [PAGE_W-1:0] page_pool[POOL_SIZE];

  function automatic lrutlb_pkg::rsp_t predict_translation(input lrutlb_pkg::req_t r);
    lrutlb_pkg::rsp_t res;
    bit found;
    logic [PAGE_W-1:0] frm;
    res = '0;
    found = 1'b0;
    if (r.mode == lrutlb_pkg::MODE_LOOKUP) begin
      lookup_total = lookup_total + 1;
      for (int i = 0; i < tlb_fill && !found; i++) begin
        if (tlb_pages[i] == r.page_number) begin
          found = 1'b1;
          frm = tlb_frames[i];
          hit_total = hit_total + 1;
          // close the gap, move the hit entry to the newest slot
          for (int j = i; j < tlb_fill - 1; j++) begin
            tlb_pages[j] = tlb_pages[j+1];
            tlb_frames[j] = tlb_frames[j+1];
          end
          tlb_pages[tlb_fill-1] = r.page_number;
          tlb_frames[tlb_fill-1] = frm;
          res.hit = 1'b1;
          res.found_frame = frm;
        end
      end
    end else if (tlb_fill < ENTRIES) begin
      tlb_pages[tlb_fill] = r.page_number;
      tlb_frames[tlb_fill] = r.frame_number;
      tlb_fill++;
    end else begin
      // drop the oldest entry
      for (int j = 0; j < ENTRIES - 1; j++) begin
        tlb_pages[j] = tlb_pages[j+1];
        tlb_frames[j] = tlb_frames[j+1];
      end
      tlb_pages[ENTRIES-1] = r.page_number;
      tlb_frames[ENTRIES-1] = r.frame_number;
    end
    res.requests_seen = lookup_total;
    res.hits_seen = hit_total;
    return res;
  endfunction

  task automatic push_req(input logic m, input logic [PAGE_W-1:0] pg,
                          input logic [PAGE_W-1:0] fr);
    lrutlb_pkg::req_t r;
    r.mode = m;
    r.page_number = pg;
    r.frame_number = fr;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random_req();
    logic [PAGE_W-1:0] pg;
    int roll;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 3)
      page_pool[$urandom_range(POOL_SIZE-1)] = PAGE_W'($urandom);
    if ($urandom_range(99) < 88)
      pg = page_pool[$urandom_range(POOL_SIZE-1)];
    else
      pg = PAGE_W'($urandom);
    push_req(roll < 45 ? lrutlb_pkg::MODE_INSERT : lrutlb_pkg::MODE_LOOKUP, pg,
             PAGE_W'($urandom));
  endtask

  // Sample after the edge has settled so a beat in flight is never missed.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: hold the beat until taken, then maybe idle.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall)
        expected_rsps.push_back(predict_translation(req));
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst)
      rsp_stall <= 1'b0;
    else
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: compare each response beat with the oldest prediction.
  always @(posedge clk) begin
    lrutlb_pkg::rsp_t want;
    bit bad;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response beat: hit=%0b frame=%h req=%0d hits=%0d",
                   rsp.hit, rsp.found_frame, rsp.requests_seen, rsp.hits_seen);
      end else begin
        want = expected_rsps.pop_front();
        bad = (rsp.hit !== want.hit) || (rsp.found_frame !== want.found_frame) ||
              (rsp.requests_seen !== want.requests_seen) ||
              (rsp.hits_seen !== want.hits_seen);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp hit=%0b frame=%h req=%0d hits=%0d, ",
                      "got hit=%0b frame=%h req=%0d hits=%0d"},
                     want.hit, want.found_frame, want.requests_seen, want.hits_seen,
                     rsp.hit, rsp.found_frame, rsp.requests_seen, rsp.hits_seen);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++)
      page_pool[i] = PAGE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 79;

    // lookup on an empty table misses
    push_req(lrutlb_pkg::MODE_LOOKUP, '0, '1);
    push_req(lrutlb_pkg::MODE_INSERT, '0, '0);
    push_req(lrutlb_pkg::MODE_INSERT, '1, '1);
    push_req(lrutlb_pkg::MODE_LOOKUP, '0, '1);
    push_req(lrutlb_pkg::MODE_LOOKUP, '1, '0);
    push_req(lrutlb_pkg::MODE_LOOKUP, 20'h12345, 20'h54321);
    // duplicate pages: oldest match wins, then the other copy becomes the older of the two
    push_req(lrutlb_pkg::MODE_INSERT, 20'h00abc, 20'h00001);
    push_req(lrutlb_pkg::MODE_INSERT, 20'h00abc, 20'h00002);
    push_req(lrutlb_pkg::MODE_LOOKUP, 20'h00abc, '0);
    push_req(lrutlb_pkg::MODE_LOOKUP, 20'h00abc, '0);
    // overfill so the oldest entries drop out
    for (int i = 0; i < 14; i++)
      push_req(lrutlb_pkg::MODE_INSERT, PAGE_W'(20'h00100 + i), PAGE_W'($urandom));
    push_req(lrutlb_pkg::MODE_LOOKUP, '0, '0);
    push_req(lrutlb_pkg::MODE_LOOKUP, 20'h00100, '0);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 79;
        recv_idle_pct = 29;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < RANDOM_ITEMS / 3; n++)
        push_random_req();
      // pause the sender until every response is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
